// File: src/mktw_pkg.sv
// Shared types and fixed-point constants for the mean kinetic temperature window block.
`default_nettype none
package mktw_pkg;

	// Temperature limits and Kelvin offset, Q8.8
	localparam logic signed [63:0] T_MIN    = -64'sd12800;
	localparam logic signed [63:0] T_MAX    = 64'sd38400;
	localparam logic [63:0]        KELV_OFS = 64'd69888;

	// 40*log2(e) in Q32 and (80/R)*log2(e) in Q16 moved up to Q40
	localparam logic signed [63:0] A_Q32  = 64'sd247853120749;
	localparam logic [63:0]        B_NUM  = 64'd909724271 << 24;
	localparam logic [31:0]        LN2_Q32 = 32'd2977044472;
	localparam logic [32:0]        ONE_Q32 = 33'h1_0000_0000;
	localparam logic [63:0]        Y_BIAS  = 64'h10_0000_0000;

	// Taylor order of the exponential and quotient widths used by the divider
	localparam logic [3:0] TAYLOR_ORDER = 4'd12;
	localparam logic [6:0] QBITS_RECIP  = 7'd56;
	localparam logic [6:0] QBITS_TERM   = 7'd33;
	localparam logic [6:0] QBITS_FULL   = 7'd64;

	// Classified item passed from front to back
	typedef struct packed {
		logic [2:0]         sensor;
		logic signed [16:0] temp;
		logic               in_range;
		logic               mkt;
	} item_t;

	// Divider request and response
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
		logic [6:0]  bits;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

endpackage
`default_nettype wire

// File: src/mean_kinetic_temperature_window_core.sv
// An item whose sensor index is beyond the window set goes straight to the result register.
// With MKT off an item takes a 56-bit reciprocal division and twelve 33-bit Taylor divisions
// on the shared one-bit divider; with MKT on it also takes a 64-bit mean division, up to 63
// normalising shifts, 32 squaring rounds and a final 56-bit division. One item is in the
// back end at a time; a two-entry queue takes further items meanwhile. Reset is asynchronous
// and clears the mask, fill counts, slots and sums at once; the term memory needs no clearing.
`default_nettype none
module mean_kinetic_temperature_window_core import mktw_pkg::*; #(
	parameter int SENSORS = 8,
	parameter int WINDOW  = 20
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [2:0]         sensor_index,
	input  wire logic signed [16:0] sample_temp,
	output logic                    empty,
	input  wire logic               pop,
	output logic [2:0]              result_sensor,
	output logic signed [16:0]      result_temp,
	output logic [4:0]              window_fill,
	input  wire logic               cfg_we,
	input  wire logic [7:0]         cfg_wdata
);
	logic  q_push, q_full, q_pop, q_empty;
	item_t q_wdata, q_rdata;

	mktw_front #(.SENSORS(SENSORS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sensor_index (sensor_index),
		.sample_temp  (sample_temp),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_push       (q_push),
		.q_full       (q_full),
		.q_item       (q_wdata)
	);

	mktw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	mktw_back #(.SENSORS(SENSORS), .WINDOW(WINDOW)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_item        (q_rdata),
		.empty         (empty),
		.pop           (pop),
		.result_sensor (result_sensor),
		.result_temp   (result_temp),
		.window_fill   (window_fill)
	);

	// Sensor beyond the window set reports an empty window
	a_oor_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && ({2'b0, result_sensor} >= 5'(SENSORS))) |-> (window_fill == 5'd0))
		else $error("window fill reported for a sensor without a window");

	// Result stays within the clamped range
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result_temp >= 17'(T_MIN) && result_temp <= 17'(T_MAX)))
		else $error("result temperature out of range");

	// The back end takes from the queue only when it holds an item
	a_q_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back end popped an empty queue");
endmodule
`default_nettype wire

// File: src/mktw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mktw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 160
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: src/mktw_div.sv
// Restoring divider, one quotient bit per cycle, shared by the back end.
`default_nettype none
module mktw_div import mktw_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic        busy_q, done_q;
	logic [6:0]  cnt_q;
	logic [63:0] dvd_q, den_q;
	logic [64:0] rem_q;
	logic [64:0] trial;
	logic        qbit;

	// Trial subtract of the next partial remainder
	always_comb begin
		trial = {rem_q[63:0], dvd_q[63]};
		qbit  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 7'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.bits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift the dividend in from the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.num << (7'd64 - req.bits);
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? (trial - {1'b0, den_q}) : trial;
			dvd_q <= {dvd_q[62:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = dvd_q;
endmodule
`default_nettype wire

// File: src/mktw_queue.sv
// Two-entry queue that decouples the front from the back.
`default_nettype none
module mktw_queue import mktw_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t wdata,
	output logic       full,
	input  wire logic  pop,
	output logic       empty,
	output item_t      rdata
);
	localparam int QDEPTH = 2;
	localparam int PW = $clog2(QDEPTH);

	item_t          buf_q [QDEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [PW:0]    cnt_q;
	logic           do_push, do_pop;

	assign full    = (cnt_q == (PW+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = buf_q[rp_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

	// Hold the item
	always_ff @(posedge clk) begin
		if (do_push) buf_q[wp_q] <= wdata;
	end
endmodule
`default_nettype wire

// File: src/mktw_front.sv
// Front end: holds the enable mask, clamps and classifies each incoming item.
`default_nettype none
module mktw_front import mktw_pkg::*; #(
	parameter int SENSORS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [2:0]         sensor_index,
	input  wire logic signed [16:0] sample_temp,
	input  wire logic               cfg_we,
	input  wire logic [7:0]         cfg_wdata,
	output logic                    q_push,
	input  wire logic               q_full,
	output item_t                   q_item
);
	logic [7:0] mask_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	// Clamp the sample and tag the sensor
	always_comb begin
		q_item.sensor   = sensor_index;
		if (sample_temp < 17'(T_MIN)) begin
			q_item.temp = 17'(T_MIN);
		end else if (sample_temp > 17'(T_MAX)) begin
			q_item.temp = 17'(T_MAX);
		end else begin
			q_item.temp = sample_temp;
		end
		q_item.in_range = ({2'b0, sensor_index} < 5'(SENSORS));
		q_item.mkt      = mask_q[sensor_index];
	end

	assign q_push = push;
	assign full   = q_full;
endmodule
`default_nettype wire

// File: src/mktw_back.sv
// Back end: window update, exp/log/divide sequence and result register.
`default_nettype none
module mktw_back import mktw_pkg::*; #(
	parameter int SENSORS = 8,
	parameter int WINDOW  = 20
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	output logic               q_pop,
	input  wire item_t         q_item,
	output logic               empty,
	input  wire logic          pop,
	output logic [2:0]         result_sensor,
	output logic signed [16:0] result_temp,
	output logic [4:0]         window_fill
);
	localparam int IW    = (SENSORS > 1) ? $clog2(SENSORS) : 1;
	localparam int SW    = $clog2(WINDOW);
	localparam int FW    = $clog2(WINDOW + 1);
	localparam int DEPTH = SENSORS * WINDOW;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_DIVQ  = 14'b00000000000010,
		ST_EXP   = 14'b00000000000100,
		ST_TMUL  = 14'b00000000001000,
		ST_TDIV  = 14'b00000000010000,
		ST_SHIFT = 14'b00000000100000,
		ST_UPD   = 14'b00000001000000,
		ST_DIVM  = 14'b00000010000000,
		ST_NORM  = 14'b00000100000000,
		ST_LOG   = 14'b00001000000000,
		ST_DEN   = 14'b00010000000000,
		ST_DIVK  = 14'b00100000000000,
		ST_OUT   = 14'b01000000000000,
		ST_SPARE = 14'b10000000000000
	} state_t;

	state_t state_q;

	// Item and result registers
	logic [2:0]         s_q;
	logic signed [16:0] res_q;
	logic               mkt_q;
	logic [4:0]         fres_q;

	// Divider request registers
	logic        dstart_q;
	logic [63:0] dnum_q, dden_q;
	logic [6:0]  dbits_q;
	div_req_t    dreq;
	div_rsp_t    drsp;

	// Exponential registers
	logic signed [8:0] e_q;
	logic [31:0]       f_q, tl_q;
	logic [32:0]       term_q;
	logic [63:0]       sum_q, nterm_q;
	logic [3:0]        k_q;

	// Logarithm registers
	logic [63:0]       v_q;
	logic signed [7:0] p_q;
	logic [30:0]       x_q;
	logic [31:0]       frac_q;
	logic [4:0]        lk_q;

	// Per-sensor window state
	logic [SW-1:0] slot_q [SENSORS];
	logic [FW-1:0] fillc_q [SENSORS];
	logic [63:0]   tsum_q [SENSORS];

	// Result register
	logic               ovalid_q;
	logic [2:0]         osens_q;
	logic signed [16:0] otemp_q;
	logic [4:0]         ofill_q;

	// Combinational helpers
	logic [IW-1:0]      si;
	logic [SW-1:0]      slot;
	logic [AW-1:0]      idx;
	logic [63:0]        old_term;
	logic [FW-1:0]      fc_new;
	logic [63:0]        sum_new;
	logic [64:0]        tprod;
	logic [63:0]        eprod;
	logic [61:0]        sq;
	logic [31:0]        x2;
	logic signed [63:0] y, yb, lval, den, kres;
	logic [63:0]        kelv;
	logic [63:0]        shifted;
	logic [8:0]         neg_e;
	logic               ram_we;

	assign dreq.start = dstart_q;
	assign dreq.num   = dnum_q;
	assign dreq.den   = dden_q;
	assign dreq.bits  = dbits_q;

	mktw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// Window slot address of the latched sensor
	always_comb begin
		si   = IW'(s_q);
		slot = (32'(slot_q[si]) >= 32'(WINDOW)) ? '0 : slot_q[si];
		idx  = AW'(32'(si) * 32'(WINDOW) + 32'(slot));
	end

	assign ram_we = (state_q == ST_UPD);

	mktw_ram #(
		.WIDTH (64),
		.DEPTH (DEPTH)
	) u_terms (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx),
		.wdata (nterm_q),
		.re    (state_q != ST_IDLE),
		.raddr (idx),
		.rdata (old_term)
	);

	// Arithmetic of the current step
	always_comb begin
		kelv  = 64'(q_item.temp) + KELV_OFS;
		y     = A_Q32 - $signed(drsp.quo);
		yb    = y + $signed(Y_BIAS);
		eprod = f_q * LN2_Q32;
		tprod = term_q * tl_q;
		sq    = x_q * x_q;
		x2    = sq[61:30];
		lval  = {32'(32'(p_q) - 32'sd32), frac_q};
		den   = A_Q32 - lval;
		kres  = $signed(drsp.quo) - $signed(KELV_OFS);
		neg_e = 9'(-e_q);
		if (e_q >= 0) begin
			shifted = sum_q << ((e_q > 9'sd30) ? 9'd30 : 9'(e_q));
		end else if (neg_e > 9'd63) begin
			shifted = '0;
		end else begin
			shifted = sum_q >> neg_e;
		end
		if (32'(fillc_q[si]) >= 32'(WINDOW)) begin
			fc_new  = FW'(WINDOW);
			sum_new = tsum_q[si] - old_term + nterm_q;
		end else begin
			fc_new  = fillc_q[si] + 1'b1;
			sum_new = tsum_q[si] + nterm_q;
		end
	end

	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			dstart_q <= 1'b0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < SENSORS; i++) begin
				slot_q[i]  <= '0;
				fillc_q[i] <= '0;
				tsum_q[i]  <= '0;
			end
		end else begin
			dstart_q <= 1'b0;
			// Load a finished item or drop the one taken
			if ((state_q == ST_OUT) && (!ovalid_q || pop)) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (q_item.in_range) begin
							dstart_q <= 1'b1;
							state_q  <= ST_DIVQ;
						end else begin
							state_q  <= ST_OUT;
						end
					end
				end
				ST_DIVQ:  if (drsp.done) state_q <= ST_EXP;
				ST_EXP:   state_q <= ST_TMUL;
				ST_TMUL: begin
					dstart_q <= 1'b1;
					state_q  <= ST_TDIV;
				end
				ST_TDIV: begin
					if (drsp.done) begin
						state_q <= (k_q == TAYLOR_ORDER) ? ST_SHIFT : ST_TMUL;
					end
				end
				ST_SHIFT: state_q <= ST_UPD;
				ST_UPD: begin
					fillc_q[si] <= fc_new;
					tsum_q[si]  <= sum_new;
					slot_q[si]  <= (32'(slot) + 1 >= 32'(WINDOW)) ? '0 : slot + 1'b1;
					if (mkt_q) begin
						dstart_q <= 1'b1;
						state_q  <= ST_DIVM;
					end else begin
						state_q  <= ST_OUT;
					end
				end
				ST_DIVM: if (drsp.done) state_q <= ST_NORM;
				ST_NORM: if (v_q[63]) state_q <= ST_LOG;
				ST_LOG:  if (lk_q == 5'd31) state_q <= ST_DEN;
				ST_DEN: begin
					if (den <= 0) begin
						state_q <= ST_OUT;
					end else begin
						dstart_q <= 1'b1;
						state_q  <= ST_DIVK;
					end
				end
				ST_DIVK: if (drsp.done) state_q <= ST_OUT;
				ST_OUT: begin
					if (!ovalid_q || pop) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				s_q     <= q_item.sensor;
				mkt_q   <= q_item.mkt;
				res_q   <= q_item.temp;
				fres_q  <= '0;
				dnum_q  <= B_NUM + (kelv >> 1);
				dden_q  <= kelv;
				dbits_q <= QBITS_RECIP;
			end
			ST_DIVQ: begin
				e_q <= $signed({1'b0, yb[39:32]}) - 9'sd16;
				f_q <= yb[31:0];
			end
			ST_EXP: begin
				tl_q   <= eprod[63:32];
				term_q <= ONE_Q32;
				sum_q  <= 64'(ONE_Q32);
				k_q    <= 4'd1;
			end
			ST_TMUL: begin
				dnum_q  <= 64'(tprod[64:32]);
				dden_q  <= 64'(k_q);
				dbits_q <= QBITS_TERM;
			end
			ST_TDIV: begin
				if (drsp.done) begin
					term_q <= drsp.quo[32:0];
					sum_q  <= sum_q + drsp.quo;
					k_q    <= k_q + 4'd1;
				end
			end
			ST_SHIFT: nterm_q <= shifted;
			ST_UPD: begin
				fres_q  <= 5'(fc_new);
				dnum_q  <= sum_new;
				dden_q  <= 64'(fc_new);
				dbits_q <= QBITS_FULL;
			end
			ST_DIVM: begin
				v_q <= (drsp.quo == '0) ? 64'd1 : drsp.quo;
				p_q <= 8'sd63;
			end
			ST_NORM: begin
				if (v_q[63]) begin
					x_q    <= v_q[63:33];
					frac_q <= '0;
					lk_q   <= '0;
				end else begin
					v_q <= v_q << 1;
					p_q <= p_q - 8'sd1;
				end
			end
			ST_LOG: begin
				if (x2[31]) begin
					x_q                   <= x2[31:1];
					frac_q[5'd31 - lk_q] <= 1'b1;
				end else begin
					x_q <= x2[30:0];
				end
				lk_q <= lk_q + 5'd1;
			end
			ST_DEN: begin
				res_q   <= 17'(T_MAX);
				dnum_q  <= B_NUM + (den >> 1);
				dden_q  <= den;
				dbits_q <= QBITS_RECIP;
			end
			ST_DIVK: begin
				if (drsp.done) begin
					if (kres < T_MIN) begin
						res_q <= 17'(T_MIN);
					end else if (kres > T_MAX) begin
						res_q <= 17'(T_MAX);
					end else begin
						res_q <= 17'(kres);
					end
				end
			end
			ST_OUT: begin
				if (!ovalid_q || pop) begin
					osens_q <= s_q;
					otemp_q <= res_q;
					ofill_q <= fres_q;
				end
			end
			default: ;
		endcase
	end

	assign empty         = !ovalid_q;
	assign result_sensor = osens_q;
	assign result_temp   = otemp_q;
	assign window_fill   = ofill_q;
endmodule
`default_nettype wire

// File: tb/sv/mean_kinetic_temperature_window_core_tb.sv
// Self-checking testbench for the mean kinetic temperature window core.
`default_nettype none
module mean_kinetic_temperature_window_core_tb import mktw_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSENS = 8;
	localparam int WIN   = 20;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [2:0]         sensor;
		logic signed [16:0] temp;
		logic [4:0]         fill;
	} mkt_result_t;

	// Fixed-point predictor with its own copy of the window state
	class mkt_scoreboard;
		logic [63:0] terms [NSENS*WIN];
		logic [4:0]  slot [NSENS];
		logic [4:0]  fill [NSENS];
		logic [63:0] sums [NSENS];
		logic [7:0]  mask;
		mkt_result_t pending [$];
		int          errors;

		function new();
			errors = 0;
			mask = '0;
			for (int s = 0; s < NSENS; s++) begin
				slot[s] = '0;
				fill[s] = '0;
				sums[s] = '0;
			end
		endfunction

		// 2^y in Q32 from a Q32 exponent
		function automatic logic [63:0] exp2_q32(logic signed [63:0] y);
			logic [63:0] yb, f, t, acc, tm;
			int e;
			yb = y + Y_BIAS;
			e = int'(yb >> 32) - 16;
			f = yb & 64'hFFFF_FFFF;
			t = (f * 64'(LN2_Q32)) >> 32;
			acc = 64'(ONE_Q32);
			tm = 64'(ONE_Q32);
			for (int k = 1; k <= 12; k++) begin
				tm = ((tm * t) >> 32) / k;
				acc += tm;
			end
			if (e >= 0) begin
				if (e > 30) e = 30;
				return acc << e;
			end
			if (-e > 63) return 0;
			return acc >> (-e);
		endfunction

		// log2 in Q32 by repeated squaring
		function automatic logic signed [63:0] log2_q32(logic [63:0] v);
			int p;
			logic [63:0] x, frac;
			p = 63;
			frac = '0;
			if (v == 0) v = 1;
			while (v[p] == 1'b0) p--;
			if (p >= 30) x = v >> (p - 30);
			else x = v << (30 - p);
			for (int k = 1; k <= 32; k++) begin
				x = (x * x) >> 30;
				if (x >= (64'd2 << 30)) begin
					x = x >> 1;
					frac |= 64'd1 << (32 - k);
				end
			end
			return $signed(64'(p - 32)) * 64'sd4294967296 + $signed(frac);
		endfunction

		// Note an accepted item and work out its result
		function void note_item(logic [2:0] s, logic signed [16:0] smp);
			mkt_result_t r;
			logic signed [63:0] t, res, den;
			logic [63:0] kel, q, term, mean, kq;
			int sl, idx;
			t = smp;
			if (t < T_MIN) t = T_MIN;
			if (t > T_MAX) t = T_MAX;
			res = t;
			kel = t + KELV_OFS;
			q = (B_NUM + kel / 2) / kel;
			term = exp2_q32(A_Q32 - $signed(q));
			sl = slot[s];
			if (sl >= WIN) sl = 0;
			idx = s * WIN + sl;
			if (fill[s] >= WIN) begin
				fill[s] = 5'(WIN);
				sums[s] -= terms[idx];
			end else begin
				fill[s]++;
			end
			terms[idx] = term;
			sums[s] += term;
			slot[s] = (sl + 1 >= WIN) ? 5'd0 : 5'(sl + 1);
			if (mask[s]) begin
				mean = sums[s] / fill[s];
				den = A_Q32 - log2_q32(mean);
				if (den <= 0) begin
					res = T_MAX;
				end else begin
					kq = (B_NUM + 64'(den) / 2) / 64'(den);
					res = $signed(kq) - $signed(KELV_OFS);
					if (res < T_MIN) res = T_MIN;
					if (res > T_MAX) res = T_MAX;
				end
			end
			r.sensor = s;
			r.temp = res[16:0];
			r.fill = fill[s];
			pending.push_back(r);
		endfunction

		// Compare a result with the oldest expectation
		function void check_result(logic [2:0] s, logic signed [16:0] tp, logic [4:0] fl);
			mkt_result_t r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result sensor=%0d temp=%0d fill=%0d",
					$time, s, tp, fl);
				errors++;
				return;
			end
			r = pending.pop_front();
			if (r.sensor !== s) begin
				$display("%0t: result_sensor expected %0d actual %0d", $time, r.sensor, s);
				errors++;
			end
			if (r.temp !== tp) begin
				$display("%0t: result_temp expected %0d actual %0d", $time, r.temp, tp);
				errors++;
			end
			if (r.fill !== fl) begin
				$display("%0t: window_fill expected %0d actual %0d", $time, r.fill, fl);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, push, full, empty, pop, cfg_we;
	logic [2:0] sensor_index, result_sensor;
	logic signed [16:0] sample_temp, result_temp;
	logic [4:0] window_fill;
	logic [7:0] cfg_wdata;

	int send_idle_pct, recv_stall_pct, idle_cycles;
	mkt_scoreboard board;

	mean_kinetic_temperature_window_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.sensor_index(sensor_index), .sample_temp(sample_temp),
		.empty(empty), .pop(pop), .result_sensor(result_sensor),
		.result_temp(result_temp), .window_fill(window_fill),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) board.note_item(sensor_index, sample_temp);
			if (pop && !empty) board.check_result(result_sensor, result_temp, window_fill);
			if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Stop the run if nothing moves for too long
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("mean_kinetic_temperature_window_core_tb NOT OK");
			$finish;
		end
	end

	// Offer one item and hold it until accepted
	task automatic send_item(logic [2:0] s, logic signed [16:0] smp);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		sensor_index <= s;
		sample_temp <= smp;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	// Wait for all results, then a margin for the block to settle
	task automatic drain();
		push <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (800) @(negedge clk);
	endtask

	task automatic write_mask(logic [7:0] m);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.mask = m;
	endtask

	function automatic logic signed [16:0] rand_temp();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) return 17'($urandom);
		if (sel == 1) return 17'(38400 + int'($urandom_range(26000)));
		if (sel == 2) return 17'(-12800 - int'($urandom_range(52000)));
		return 17'(int'($urandom_range(51200)) - 12800);
	endfunction

	initial begin
		logic [7:0] masks [5];
		board = new();
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sensor_index = '0;
		sample_temp = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, clamping, both modes, 18 items into one window without a wrap
		write_mask(8'hAA);
		send_item(3'd0, -17'sd12800);
		send_item(3'd1, 17'sd38400);
		send_item(3'd2, -17'sd65536);
		send_item(3'd3, 17'sd65535);
		send_item(3'd4, 17'sd0);
		send_item(3'd5, -17'sd12801);
		send_item(3'd6, 17'sd38401);
		send_item(3'd7, 17'sd6400);
		for (int i = 0; i < 17; i++) send_item(3'd7, (i % 2) ? 17'sd38400 : -17'sd12800);
		drain();

		// Random phases over several masks and idling profiles
		masks[0] = 8'hFF; masks[1] = 8'h00; masks[2] = 8'h5A;
		masks[3] = 8'($urandom); masks[4] = 8'hFF;
		for (int ph = 0; ph < 5; ph++) begin
			write_mask(masks[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			for (int i = 0; i < 205; i++) send_item(3'($urandom_range(7)), rand_temp());
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("mean_kinetic_temperature_window_core_tb OK");
		end else begin
			$display("mean_kinetic_temperature_window_core_tb NOT OK");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
src/mktw_pkg.sv
src/mktw_ram.sv
src/mktw_div.sv
src/mktw_queue.sv
src/mktw_front.sv
src/mktw_back.sv
src/mean_kinetic_temperature_window_core.sv
tb/sv/mean_kinetic_temperature_window_core_tb.sv
